// ===== design/owner_tagged_byte_ring_fifo_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the owner-tagged byte ring FIFO
// Shared concurrent assertion forms, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef OWNER_TAGGED_BYTE_RING_FIFO_MACROS_SVH
`define OWNER_TAGGED_BYTE_RING_FIFO_MACROS_SVH

// Check outside reset only.
`define OTBRF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check at every edge, reset included.
`define OTBRF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/otbrf_pkg.sv =====
// ----------------------------------------------------------------------------
// otbrf_pkg
// Types and constants for the owner-tagged byte ring FIFO.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package otbrf_pkg;

    localparam int DEPTH   = 4096;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int LEVEL_W = $clog2(DEPTH + 1);

    // Field widths
    localparam int OP_W      = 3;
    localparam int BYTE_W    = 8;
    localparam int SESSION_W = 16;
    localparam int GEN_W     = 32;
    localparam int STATUS_W  = 3;
    localparam int MAXSZ_W   = 13;
    localparam int COUNT_W   = 32;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 64;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_SIZE         = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OWNER_SESSION    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OWNER_GENERATION = 2'd2;

    localparam logic [MAXSZ_W-1:0] MAX_SIZE_RESET = 13'd4096;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE       = 3'd0,
        OP_READ        = 3'd1,
        OP_CLEAR       = 3'd2,
        OP_FLUSH       = 3'd3,
        OP_DISCARD_ON  = 3'd4,
        OP_DISCARD_OFF = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_STALE     = 3'd1,
        ST_DISCARDED = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

endpackage

// ===== design/owner_tagged_byte_ring_fifo.sv =====
// ----------------------------------------------------------------------------
// owner_tagged_byte_ring_fifo
// Byte ring FIFO with an occupancy limit, owner-tag checks and discard mode.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_*) carries one operation per transaction: write, read,
//   clear, flush-and-discard, discard on, discard off. Every operation gives
//   exactly one result transaction on the master stream (m_*), in order.
//   The config port (cfg_we/cfg_addr/cfg_wdata) sets the occupancy limit and
//   the owner session and generation; write it only while the block is idle.
// Timing:
//   An operation lands in the input register at its accept edge and its
//   result is then registered in the output register, which drives m_tvalid.
//   One operation per cycle is sustained while m_tready is high: all
//   pointer, count and owner checks are single-step, and the 4096x8 byte
//   store takes one write and one registered read per cycle.
// Reset and stalls:
//   Reset empties the FIFO, clears discard mode and the drop counter, and
//   restores the limit to 4096 and both owner values to zero. Store contents
//   are not cleared; only written bytes are ever read back.
//   When m_tready is low, the result holds and s_tready follows, with one
//   more operation taken into the input register before the input stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module owner_tagged_byte_ring_fifo (
    input  logic                                clk,
    input  logic                                rst_n,
    // cfg_addr: 0 max_size, 1 owner_session, 2 owner_generation
    input  logic                                cfg_we,
    input  logic [otbrf_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [otbrf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // s_tdata: operation[2:0], write_data[10:3], session_id[26:11],
    //          generation[58:27], zero[63:59]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [otbrf_pkg::IN_DATA_W-1:0]     s_tdata,
    // m_tdata: read_data[7:0], read_valid[8], write_accepted[9], status[12:10],
    //          level[25:13], discarding[26], discarded_bytes[58:27], zero[63:59]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [otbrf_pkg::OUT_DATA_W-1:0]    m_tdata
);
    import otbrf_pkg::*;

    // Configuration
    logic [MAXSZ_W-1:0]   max_size_reg;
    logic [SESSION_W-1:0] owner_session_reg;
    logic [GEN_W-1:0]     owner_gen_reg;

    // FIFO state
    logic [ADDR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [ADDR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [LEVEL_W-1:0] occ_reg, occ_next;
    logic               discard_reg, discard_next;
    logic [COUNT_W-1:0] drop_reg, drop_next;

    // Input register
    logic                 s1_valid_reg;
    logic [OP_W-1:0]      s1_op_reg;
    logic [BYTE_W-1:0]    s1_wdata_reg;
    logic [SESSION_W-1:0] s1_session_reg;
    logic [GEN_W-1:0]     s1_gen_reg;

    // Result register
    logic                 out_valid_reg;
    logic [BYTE_W-1:0]    rdata_reg;
    logic                 out_rvalid_reg, out_rvalid_next;
    logic                 out_wacc_reg, out_wacc_next;
    status_t              out_status_reg, out_status_next;
    logic [LEVEL_W-1:0]   out_level_reg, out_level_next;
    logic                 out_discard_reg;
    logic [COUNT_W-1:0]   out_drop_reg;

    logic [BYTE_W-1:0] byte_store [DEPTH];

    logic               out_free;
    logic               s1_adv;
    logic               in_take;
    logic               stale;
    logic [LEVEL_W-1:0] limit;
    logic               mem_we;
    logic [COUNT_W-1:0] drop_inc;

    assign out_free = !out_valid_reg || m_tready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign in_take  = s_tvalid && s_tready;

    assign stale = ((owner_session_reg != '0) && (owner_session_reg != s1_session_reg))
                || ((owner_gen_reg != '0) && (owner_gen_reg != s1_gen_reg));

    assign limit = (32'(max_size_reg) < 32'(DEPTH)) ? LEVEL_W'(max_size_reg)
                                                    : LEVEL_W'(DEPTH);

    assign drop_inc = (drop_reg == '1) ? drop_reg : drop_reg + 1'b1;

    always_comb
    begin
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        occ_next        = occ_reg;
        discard_next    = discard_reg;
        drop_next       = drop_reg;
        mem_we          = 1'b0;
        out_rvalid_next = 1'b0;
        out_wacc_next   = 1'b0;
        out_status_next = ST_OK;
        out_level_next  = occ_reg;

        case (op_t'(s1_op_reg))
            OP_WRITE:
            begin
                if (stale)
                begin
                    drop_next       = drop_inc;
                    out_status_next = ST_STALE;
                end
                else if (discard_reg)
                begin
                    drop_next       = drop_inc;
                    out_status_next = ST_DISCARDED;
                end
                else if (occ_reg >= limit)
                begin
                    out_status_next = ST_FULL;
                end
                else
                begin
                    mem_we        = 1'b1;
                    wr_ptr_next   = (wr_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
                    occ_next      = occ_reg + 1'b1;
                    out_wacc_next = 1'b1;
                end
                out_level_next = occ_next;
            end
            OP_READ:
            begin
                if (stale)
                begin
                    out_status_next = ST_STALE;
                end
                else if (occ_reg == '0)
                begin
                    out_status_next = ST_EMPTY;
                end
                else
                begin
                    out_rvalid_next = 1'b1;
                    rd_ptr_next     = (rd_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
                    occ_next        = occ_reg - 1'b1;
                end
                out_level_next = occ_next;
            end
            OP_CLEAR:
            begin
                rd_ptr_next    = '0;
                wr_ptr_next    = '0;
                occ_next       = '0;
                out_level_next = '0;
            end
            OP_FLUSH:
            begin
                // report the level held before the flush
                rd_ptr_next  = '0;
                wr_ptr_next  = '0;
                occ_next     = '0;
                discard_next = 1'b1;
            end
            OP_DISCARD_ON:
            begin
                discard_next = 1'b1;
            end
            OP_DISCARD_OFF:
            begin
                discard_next = 1'b0;
                drop_next    = '0;
            end
            default:
            begin
                out_status_next = ST_OK;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_size_reg      <= MAX_SIZE_RESET;
            owner_session_reg <= '0;
            owner_gen_reg     <= '0;
            rd_ptr_reg        <= '0;
            wr_ptr_reg        <= '0;
            occ_reg           <= '0;
            discard_reg       <= 1'b0;
            drop_reg          <= '0;
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_MAX_SIZE:         max_size_reg      <= cfg_wdata[MAXSZ_W-1:0];
                    REG_OWNER_SESSION:    owner_session_reg <= cfg_wdata[SESSION_W-1:0];
                    REG_OWNER_GENERATION: owner_gen_reg     <= cfg_wdata[GEN_W-1:0];
                    default:              ;
                endcase
            end

            if (s1_adv)
            begin
                rd_ptr_reg  <= rd_ptr_next;
                wr_ptr_reg  <= wr_ptr_next;
                occ_reg     <= occ_next;
                discard_reg <= discard_next;
                drop_reg    <= drop_next;
            end

            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid;
            end

            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Input and result payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_op_reg      <= s_tdata[2:0];
            s1_wdata_reg   <= s_tdata[10:3];
            s1_session_reg <= s_tdata[26:11];
            s1_gen_reg     <= s_tdata[58:27];
        end

        if (s1_adv)
        begin
            out_rvalid_reg  <= out_rvalid_next;
            out_wacc_reg    <= out_wacc_next;
            out_status_reg  <= out_status_next;
            out_level_reg   <= out_level_next;
            out_discard_reg <= discard_next;
            out_drop_reg    <= drop_next;
        end
    end

    // Byte store: one write, one registered read; read data advances with the result
    always_ff @(posedge clk)
    begin
        if (s1_adv && mem_we)
        begin
            byte_store[wr_ptr_reg] <= s1_wdata_reg;
        end
        if (s1_adv)
        begin
            rdata_reg <= byte_store[rd_ptr_reg];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0,
                       out_drop_reg,
                       out_discard_reg,
                       out_level_reg,
                       out_status_reg,
                       out_wacc_reg,
                       out_rvalid_reg,
                       (out_rvalid_reg ? rdata_reg : 8'h00)};

endmodule

// ===== design/otbrf_checker.sv =====
// ----------------------------------------------------------------------------
// otbrf_checker
// Port-level checks on the owner-tagged byte ring FIFO, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "owner_tagged_byte_ring_fifo_macros.svh"

module otbrf_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [otbrf_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import otbrf_pkg::*;

    // Hold a stalled result
    `OTBRF_ASSERT(a_result_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

    // No result transaction while or right after reset is asserted
    `OTBRF_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !m_tvalid, "result valid during reset")

    // Read byte is zero unless a byte was dequeued
    `OTBRF_ASSERT(a_rdata_clean, m_tvalid && !m_tdata[8] |-> m_tdata[7:0] == 8'h00, "read_data set without read_valid")

    // An accepted write implies discard mode off and status ok
    `OTBRF_ASSERT(a_wacc_mode, m_tvalid && m_tdata[9] |-> !m_tdata[26] && m_tdata[12:10] == ST_OK, "write accepted while discarding")

    // Level never passes the store depth
    `OTBRF_ASSERT(a_level_range, m_tvalid |-> 32'(m_tdata[25:13]) <= 32'(DEPTH), "level above depth")

endmodule

bind owner_tagged_byte_ring_fifo otbrf_checker u_otbrf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
